>>> design/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Register indexes, reset values of the timing registers, and the structs
// passed between the configuration bank, the step logic and the top level.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int TIMER_BITS_DEF = 10;

	// Operation codes of an input item.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_REC    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WR1_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WR1_TAIL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WR0_LOW      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RD_LOW       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RD_TAIL      = 3'd7;

	// Reset values of the timing registers, in microseconds.
	localparam logic [CFG_W-1:0] RST_RESET_LOW = 10'd500;
	localparam logic [CFG_W-1:0] RST_PRES_WAIT = 10'd80;
	localparam logic [CFG_W-1:0] RST_RESET_REC = 10'd500;
	localparam logic [CFG_W-1:0] RST_WR1_LOW   = 10'd2;
	localparam logic [CFG_W-1:0] RST_WR1_TAIL  = 10'd60;
	localparam logic [CFG_W-1:0] RST_WR0_LOW   = 10'd60;
	localparam logic [CFG_W-1:0] RST_RD_LOW    = 10'd2;
	localparam logic [CFG_W-1:0] RST_RD_TAIL   = 10'd50;

	typedef struct packed {
		logic [CFG_W-1:0] reset_low;
		logic [CFG_W-1:0] presence_wait;
		logic [CFG_W-1:0] reset_recovery;
		logic [CFG_W-1:0] write_one_low;
		logic [CFG_W-1:0] write_one_tail;
		logic [CFG_W-1:0] write_zero_low;
		logic [CFG_W-1:0] read_low;
		logic [CFG_W-1:0] read_tail;
	} owm_cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] read_byte;
		logic       ignored;
	} owm_result_t;

endpackage

>>> design/one_wire_master.sv
// ----------------------------------------------------------------------------
// one_wire_master: 1-Wire bus master paced by microsecond ticks
// Each input transfer is one tick and may start a reset, byte write or byte
// read; each output transfer reports drive, busy, done and the command result.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+-------------------
//   in      | in_valid, in_stall, operation,    | tick items in
//           | write_byte, line_level            |
//   out     | out_valid, out_stall, drive_low,  | one result per tick
//           | busy_res, done_res, presence,     |
//           | read_byte, ignored                |
//   cfg     | cfg_we, cfg_index, cfg_data       | timing registers
//
// One tick is accepted every cycle while in_stall is low. It is held in the
// input register, and its result is loaded into the result register once that
// register is free or drains, and is offered from there.
// Reset clears the sequencer to idle and loads the default timing values.
// A stall on the output holds the result register and, once the input
// register is also full, raises in_stall.
// ----------------------------------------------------------------------------
module one_wire_master import owm_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           operation,
	input  logic [7:0]           write_byte,
	input  logic                 line_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 drive_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 presence,
	output logic [7:0]           read_byte,
	output logic                 ignored,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	owm_cfg_t    cfg;
	owm_result_t result;
	owm_result_t result_q;

	logic       valid_s1;
	logic [1:0] operation_s1;
	logic [7:0] write_byte_s1;
	logic       line_level_s1;
	logic       out_valid_q;
	logic       advance;

	// The input register moves on when the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			operation_s1  <= operation;
			write_byte_s1 <= write_byte;
			line_level_s1 <= line_level;
		end
	end

	owm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owm_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.cfg        (cfg),
		.operation  (operation_s1),
		.write_byte (write_byte_s1),
		.line_level (line_level_s1),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_low = result_q.drive_low;
	assign busy_res  = result_q.busy;
	assign done_res  = result_q.done;
	assign presence  = result_q.presence;
	assign read_byte = result_q.read_byte;
	assign ignored   = result_q.ignored;

endmodule

>>> design/owm_cfg.sv
// ----------------------------------------------------------------------------
// owm_cfg: timing register bank
// Eight 10-bit slot and pulse lengths, written through a plain write port.
// ----------------------------------------------------------------------------
module owm_cfg import owm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output owm_cfg_t             cfg
);

	owm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low      <= RST_RESET_LOW;
			cfg_q.presence_wait  <= RST_PRES_WAIT;
			cfg_q.reset_recovery <= RST_RESET_REC;
			cfg_q.write_one_low  <= RST_WR1_LOW;
			cfg_q.write_one_tail <= RST_WR1_TAIL;
			cfg_q.write_zero_low <= RST_WR0_LOW;
			cfg_q.read_low       <= RST_RD_LOW;
			cfg_q.read_tail      <= RST_RD_TAIL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESET_LOW: cfg_q.reset_low      <= cfg_data;
				REG_PRES_WAIT: cfg_q.presence_wait  <= cfg_data;
				REG_RESET_REC: cfg_q.reset_recovery <= cfg_data;
				REG_WR1_LOW:   cfg_q.write_one_low  <= cfg_data;
				REG_WR1_TAIL:  cfg_q.write_one_tail <= cfg_data;
				REG_WR0_LOW:   cfg_q.write_zero_low <= cfg_data;
				REG_RD_LOW:    cfg_q.read_low       <= cfg_data;
				REG_RD_TAIL:   cfg_q.read_tail      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/owm_step.sv
// ----------------------------------------------------------------------------
// owm_step: bus sequencer for one microsecond tick
// Holds the phase, timer and bit state and works out the drive and status of
// one tick from the registered input item.
// ----------------------------------------------------------------------------
module owm_step import owm_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  owm_cfg_t    cfg,
	input  logic [1:0]  operation,
	input  logic [7:0]  write_byte,
	input  logic        line_level,
	output owm_result_t result
);

	localparam int WW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
	localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_RST_LOW    = 4'd1;
	localparam logic [3:0] PH_RST_WAIT   = 4'd2;
	localparam logic [3:0] PH_RST_SAMPLE = 4'd3;
	localparam logic [3:0] PH_RST_REC    = 4'd4;
	localparam logic [3:0] PH_WR_LOW     = 4'd5;
	localparam logic [3:0] PH_WR_TAIL    = 4'd6;
	localparam logic [3:0] PH_RD_LOW     = 4'd7;
	localparam logic [3:0] PH_RD_SAMPLE  = 4'd8;
	localparam logic [3:0] PH_RD_TAIL    = 4'd9;

	logic [3:0]            phase_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic [2:0]            bit_q;
	logic [7:0]            shift_q;
	logic                  pres_q;

	logic [3:0]            ph, ph_tick;
	logic [TIMER_BITS-1:0] tm, tail;
	logic [2:0]            bi;
	logic [7:0]            sh;
	logic                  pf;
	logic                  fin, adv_wr, adv_rd;

	// A length register mapped onto the timer: zero counts as one tick where
	// min1 is set, and values beyond the timer range saturate.
	function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [CFG_W-1:0] v,
			input logic min1);
		logic [WW-1:0] ext;
		ext = WW'(v);
		if (min1 && v == '0) begin
			ext = WW'(1);
		end
		if (ext > WW'(TIMER_MAX)) begin
			return TIMER_MAX;
		end
		return TIMER_BITS'(ext);
	endfunction

	always_comb begin
		ph     = phase_q;
		tm     = timer_q;
		bi     = bit_q;
		sh     = shift_q;
		pf     = pres_q;
		fin    = 1'b0;
		adv_wr = 1'b0;
		adv_rd = 1'b0;
		tail   = '0;
		result = '0;

		// A command starts on the tick that carries it if the sequencer is idle; else it is flagged as ignored.
		if (phase_q == PH_IDLE) begin
			case (operation)
				OP_RESET: begin
					bi = '0;
					ph = PH_RST_LOW;
					tm = clamp_len(cfg.reset_low, 1'b1);
				end
				OP_WRITE: begin
					sh = write_byte;
					bi = '0;
					ph = PH_WR_LOW;
					tm = write_byte[0] ? clamp_len(cfg.write_one_low, 1'b1)
						: clamp_len(cfg.write_zero_low, 1'b1);
				end
				OP_READ: begin
					sh = '0;
					bi = '0;
					ph = PH_RD_LOW;
					tm = clamp_len(cfg.read_low, 1'b1);
				end
				default: ;
			endcase
		end else if (operation != OP_TICK) begin
			result.ignored = 1'b1;
		end

		ph_tick = ph;
		if (ph_tick != PH_IDLE) begin
			result.busy      = 1'b1;
			result.drive_low = (ph_tick == PH_RST_LOW) || (ph_tick == PH_WR_LOW) ||
				(ph_tick == PH_RD_LOW);
			if (ph_tick == PH_RST_SAMPLE) begin
				pf = ~line_level;
			end
			if (ph_tick == PH_RD_SAMPLE) begin
				sh = {line_level, sh[7:1]};
			end

			if (tm <= TIMER_ONE) begin
				case (ph_tick)
					PH_RST_LOW: begin
						ph = PH_RST_WAIT;
						tm = clamp_len(cfg.presence_wait, 1'b1);
					end
					PH_RST_WAIT: begin
						ph = PH_RST_SAMPLE;
						tm = TIMER_ONE;
					end
					PH_RST_SAMPLE: begin
						tail = clamp_len(cfg.reset_recovery, 1'b0);
						if (tail == '0) begin
							fin = 1'b1;
						end else begin
							ph = PH_RST_REC;
							tm = tail;
						end
					end
					PH_RST_REC: fin = 1'b1;
					PH_WR_LOW: begin
						// A zero bit has no released tail.
						tail = sh[0] ? clamp_len(cfg.write_one_tail, 1'b0) : '0;
						if (tail == '0) begin
							adv_wr = 1'b1;
						end else begin
							ph = PH_WR_TAIL;
							tm = tail;
						end
					end
					PH_WR_TAIL: adv_wr = 1'b1;
					PH_RD_LOW: begin
						ph = PH_RD_SAMPLE;
						tm = TIMER_ONE;
					end
					PH_RD_SAMPLE: begin
						tail = clamp_len(cfg.read_tail, 1'b0);
						if (tail == '0) begin
							adv_rd = 1'b1;
						end else begin
							ph = PH_RD_TAIL;
							tm = tail;
						end
					end
					PH_RD_TAIL: adv_rd = 1'b1;
					default: fin = 1'b1;
				endcase

				if (adv_wr) begin
					if (bi == 3'd7) begin
						fin = 1'b1;
					end else begin
						bi = bi + 3'd1;
						sh = {1'b0, sh[7:1]};
						ph = PH_WR_LOW;
						tm = sh[0] ? clamp_len(cfg.write_one_low, 1'b1)
							: clamp_len(cfg.write_zero_low, 1'b1);
					end
				end
				if (adv_rd) begin
					if (bi == 3'd7) begin
						fin = 1'b1;
					end else begin
						bi = bi + 3'd1;
						ph = PH_RD_LOW;
						tm = clamp_len(cfg.read_low, 1'b1);
					end
				end

				if (fin) begin
					ph = PH_IDLE;
					tm = '0;
					bi = '0;
					result.done = 1'b1;
					if (ph_tick >= PH_RST_LOW && ph_tick <= PH_RST_REC) begin
						result.presence = pf;
					end
					if (ph_tick >= PH_RD_LOW && ph_tick <= PH_RD_TAIL) begin
						result.read_byte = sh;
					end
				end
			end else begin
				tm = tm - TIMER_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= ph;
			timer_q <= tm;
			bit_q   <= bi;
			shift_q <= sh;
			pres_q  <= pf;
		end
	end

endmodule

>>> test/one_wire_master_checker.sv
// ----------------------------------------------------------------------------
// one_wire_master_checker: result predictor and scoreboard for the bus master
// Watches the tick and result channels and steps its own model of the slot
// sequencer on every accepted tick transfer. Each accepted result transfer is
// compared with the oldest prediction. Timing register writes are copied into
// the model as they happen on the configuration port.
// ----------------------------------------------------------------------------
module one_wire_master_checker import owm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           operation,
	input  logic [7:0]           write_byte,
	input  logic                 line_level,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 drive_low,
	input  logic                 busy_res,
	input  logic                 done_res,
	input  logic                 presence,
	input  logic [7:0]           read_byte,
	input  logic                 ignored,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   results_owed,
	output logic                 seq_idle
);

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_RST_LOW,
		SEQ_RST_WAIT,
		SEQ_RST_SAMPLE,
		SEQ_RST_REC,
		SEQ_WR_LOW,
		SEQ_WR_TAIL,
		SEQ_RD_LOW,
		SEQ_RD_SAMPLE,
		SEQ_RD_TAIL
	} seq_phase_e;

	owm_cfg_t         timing;
	seq_phase_e       phase_q;
	logic [CFG_W-1:0] ticks_left;
	logic [2:0]       bit_no;
	logic [7:0]       shreg;
	logic             pres_flag;
	owm_result_t      tick_results[$];
	owm_result_t      got;
	owm_result_t      want;
	int               fail_count;

	function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
		return (v == '0) ? CFG_W'(1) : v;
	endfunction

	function automatic logic [CFG_W-1:0] phase_ticks(input seq_phase_e p);
		case (p)
		SEQ_RST_LOW: return at_least_one(timing.reset_low);
		SEQ_RST_WAIT: return at_least_one(timing.presence_wait);
		SEQ_RST_SAMPLE: return CFG_W'(1);
		SEQ_RST_REC: return timing.reset_recovery;
		SEQ_WR_LOW: return shreg[0] ? at_least_one(timing.write_one_low)
			: at_least_one(timing.write_zero_low);
		SEQ_WR_TAIL: return shreg[0] ? timing.write_one_tail : '0;
		SEQ_RD_LOW: return at_least_one(timing.read_low);
		SEQ_RD_SAMPLE: return CFG_W'(1);
		SEQ_RD_TAIL: return timing.read_tail;
		default: return '0;
		endcase
	endfunction

	// Next phase after p; the end of a bit slot moves the bit counters on.
	function automatic seq_phase_e advance_from(input seq_phase_e p);
		case (p)
		SEQ_RST_LOW: return SEQ_RST_WAIT;
		SEQ_RST_WAIT: return SEQ_RST_SAMPLE;
		SEQ_RST_SAMPLE: return SEQ_RST_REC;
		SEQ_WR_LOW: return SEQ_WR_TAIL;
		SEQ_WR_TAIL: begin
			if (bit_no == 3'd7) begin
				bit_no = '0;
				return SEQ_IDLE;
			end
			bit_no = bit_no + 3'd1;
			shreg = shreg >> 1;
			return SEQ_WR_LOW;
		end
		SEQ_RD_LOW: return SEQ_RD_SAMPLE;
		SEQ_RD_SAMPLE: return SEQ_RD_TAIL;
		SEQ_RD_TAIL: begin
			if (bit_no == 3'd7) begin
				bit_no = '0;
				return SEQ_IDLE;
			end
			bit_no = bit_no + 3'd1;
			return SEQ_RD_LOW;
		end
		default: return SEQ_IDLE;
		endcase
	endfunction

	// Phases of zero length are passed over; returns 1 when the command is over.
	function automatic bit enter_phase(input seq_phase_e start);
		seq_phase_e p;
		p = start;
		while (p != SEQ_IDLE && phase_ticks(p) == '0)
			p = advance_from(p);
		phase_q = p;
		ticks_left = (p == SEQ_IDLE) ? '0 : phase_ticks(p);
		return p == SEQ_IDLE;
	endfunction

	function automatic owm_result_t step_sequencer(input logic [1:0] op,
		input logic [7:0] wb, input logic line);
		owm_result_t r;
		seq_phase_e  p;
		r = '0;
		if (phase_q == SEQ_IDLE) begin
			case (op)
			OP_RESET: begin
				bit_no = '0;
				void'(enter_phase(SEQ_RST_LOW));
			end
			OP_WRITE: begin
				shreg = wb;
				bit_no = '0;
				void'(enter_phase(SEQ_WR_LOW));
			end
			OP_READ: begin
				shreg = '0;
				bit_no = '0;
				void'(enter_phase(SEQ_RD_LOW));
			end
			default: ;
			endcase
		end else if (op != OP_TICK) begin
			r.ignored = 1'b1;
		end
		p = phase_q;
		if (p != SEQ_IDLE) begin
			r.busy = 1'b1;
			r.drive_low = (p == SEQ_RST_LOW || p == SEQ_WR_LOW || p == SEQ_RD_LOW);
			if (p == SEQ_RST_SAMPLE)
				pres_flag = ~line;
			if (p == SEQ_RD_SAMPLE)
				shreg = {line, shreg[7:1]};
			if (ticks_left <= 1) begin
				if (enter_phase(advance_from(p))) begin
					r.done = 1'b1;
					if (p >= SEQ_RST_LOW && p <= SEQ_RST_REC)
						r.presence = pres_flag;
					if (p >= SEQ_RD_LOW && p <= SEQ_RD_TAIL)
						r.read_byte = shreg;
				end
			end else begin
				ticks_left = ticks_left - 1'b1;
			end
		end
		return r;
	endfunction

	function automatic string show(input owm_result_t r);
		return $sformatf("drive_low=%b busy=%b done=%b presence=%b read_byte=%h ignored=%b",
			r.drive_low, r.busy, r.done, r.presence, r.read_byte, r.ignored);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing = {RST_RESET_LOW, RST_PRES_WAIT, RST_RESET_REC, RST_WR1_LOW,
				RST_WR1_TAIL, RST_WR0_LOW, RST_RD_LOW, RST_RD_TAIL};
			phase_q = SEQ_IDLE;
			ticks_left = '0;
			bit_no = '0;
			shreg = '0;
			pres_flag = 1'b0;
			tick_results.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.drive_low = drive_low;
				got.busy = busy_res;
				got.done = done_res;
				got.presence = presence;
				got.read_byte = read_byte;
				got.ignored = ignored;
				if (tick_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("one_wire_master: result with none expected: %s", show(got));
				end else begin
					want = tick_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("one_wire_master: mismatch\n  expected %s\n  actual   %s",
								show(want), show(got));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_RESET_LOW: timing.reset_low = cfg_data;
				REG_PRES_WAIT: timing.presence_wait = cfg_data;
				REG_RESET_REC: timing.reset_recovery = cfg_data;
				REG_WR1_LOW: timing.write_one_low = cfg_data;
				REG_WR1_TAIL: timing.write_one_tail = cfg_data;
				REG_WR0_LOW: timing.write_zero_low = cfg_data;
				REG_RD_LOW: timing.read_low = cfg_data;
				REG_RD_TAIL: timing.read_tail = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				tick_results.push_back(step_sequencer(operation, write_byte, line_level));
		end
		// Published with nonblocking assignments so the stimulus side reads them race free.
		mismatches <= fail_count;
		results_owed <= tick_results.size();
		seq_idle <= (phase_q == SEQ_IDLE);
	end

endmodule

>>> test/tb_one_wire_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_master: testbench of the 1-Wire bus master
// Drives microsecond ticks with commands, random bus levels, random gaps on
// the tick channel and random stalls on the result channel. A checker beside
// the block predicts every result; this module makes the stimulus, walks the
// timing registers through defaults, zeros and short random settings, and
// reports the verdict.
// ----------------------------------------------------------------------------
module tb_one_wire_master import owm_pkg::*; ();

	localparam int CYCLE_LIMIT   = 200_000;
	localparam int RANDOM_PHASES = 6;
	localparam int RANDOM_ITEMS  = 420;

	typedef enum {LVL_LOW, LVL_HIGH, LVL_RAND} level_mode_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           operation = OP_TICK;
	logic [7:0]           write_byte = '0;
	logic                 line_level = 1'b1;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 drive_low;
	logic                 busy_res;
	logic                 done_res;
	logic                 presence;
	logic [7:0]           read_byte;
	logic                 ignored;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   mismatches;
	int                   results_owed;
	logic                 seq_idle;
	int                   cycle_count = 0;
	bit                   in_quiet = 1'b0;
	bit                   out_quiet = 1'b0;

	one_wire_master dut (.*);

	one_wire_master_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_one_wire_master: done, errors");
		$finish;
	end

	// Result side: a random hold before each transfer, unless running quiet.
	initial begin
		int hold;
		forever begin
			hold = out_quiet ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	function automatic logic level_for(input level_mode_e mode);
		case (mode)
		LVL_LOW: return 1'b0;
		LVL_HIGH: return 1'b1;
		default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] short_len();
		return ($urandom_range(0, 99) < 80) ? CFG_W'($urandom_range(0, 3))
			: CFG_W'($urandom_range(4, 12));
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [7:0] wb, input logic lvl);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		write_byte <= wb;
		line_level <= lvl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Ticks until the running command is over. The idle flag trails by one
	// transfer, which is harmless since only plain ticks are sent here.
	task automatic run_until_idle(input level_mode_e mode);
		in_valid <= 1'b0;
		@(posedge clk);
		while (!seq_idle)
			send_item(OP_TICK, 8'($urandom_range(0, 255)), level_for(mode));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Caller makes sure the sequencer is idle; this waits for the pipeline to empty.
	task automatic set_timing(input owm_cfg_t t);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_RESET_LOW, t.reset_low);
		write_reg(REG_PRES_WAIT, t.presence_wait);
		write_reg(REG_RESET_REC, t.reset_recovery);
		write_reg(REG_WR1_LOW, t.write_one_low);
		write_reg(REG_WR1_TAIL, t.write_one_tail);
		write_reg(REG_WR0_LOW, t.write_zero_low);
		write_reg(REG_RD_LOW, t.read_low);
		write_reg(REG_RD_TAIL, t.read_tail);
		cfg_we <= 1'b0;
	endtask

	initial begin
		owm_cfg_t   t;
		logic [1:0] op;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Default timing: a byte with a one and seven zeros goes out, with
		// commands dropped while it runs.
		send_item(OP_WRITE, 8'h01, 1'b1);
		send_item(OP_RESET, 8'h00, 1'b0);
		send_item(OP_READ, 8'h00, 1'b0);
		run_until_idle(LVL_RAND);
		send_item(OP_TICK, 8'h00, 1'b1);

		// All zero: low times and the presence wait shrink to one tick, while
		// tails and the recovery disappear.
		set_timing('0);
		send_item(OP_RESET, 8'h00, 1'b1);
		run_until_idle(LVL_HIGH);
		send_item(OP_WRITE, 8'h00, 1'b0);
		send_item(OP_WRITE, 8'hA5, 1'b0);
		run_until_idle(LVL_RAND);
		send_item(OP_WRITE, 8'h5A, 1'b0);
		run_until_idle(LVL_RAND);
		send_item(OP_READ, 8'h00, 1'b0);
		run_until_idle(LVL_LOW);
		send_item(OP_READ, 8'h00, 1'b1);
		run_until_idle(LVL_RAND);

		// Short random timing so that many commands complete; commands also
		// land on busy ticks and get dropped.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			in_quiet = (ph == 0 || ph == 2);
			out_quiet = (ph == 0 || ph == 3);
			t.reset_low = short_len();
			t.presence_wait = short_len();
			t.reset_recovery = short_len();
			t.write_one_low = short_len();
			t.write_one_tail = short_len();
			t.write_zero_low = short_len();
			t.read_low = short_len();
			t.read_tail = short_len();
			set_timing(t);
			repeat (RANDOM_ITEMS / RANDOM_PHASES) begin
				if ($urandom_range(0, 99) < 12) begin
					case ($urandom_range(0, 2))
					0: op = OP_RESET;
					1: op = OP_WRITE;
					default: op = OP_READ;
					endcase
				end else begin
					op = OP_TICK;
				end
				send_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			run_until_idle(LVL_RAND);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_one_wire_master: done, clean");
		else
			$display("tb_one_wire_master: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
design/owm_pkg.sv
design/owm_cfg.sv
design/owm_step.sv
design/one_wire_master.sv
test/one_wire_master_checker.sv
test/tb_one_wire_master.sv
